// ===== rtl/wsfd_pkg.sv =====
// wsfd_pkg: shared types and codes for the websocket frame decoder
// no dependencies
`timescale 1ns / 1ps
package wsfd_pkg;
   localparam logic [31:0] MaxPayloadReset = 32'd65535;
   localparam int          QueueDepth      = 4;

   typedef enum logic [2:0] {
      KIND_PAYLOAD  = 3'd0,
      KIND_TERM     = 3'd1,
      KIND_CLOSE    = 3'd2,
      KIND_EMPTYBIN = 3'd3,
      KIND_BADOP    = 3'd4,
      KIND_TRUNC    = 3'd5,
      KIND_TOOLONG  = 3'd6
   } kind_type;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;

   // one step's work, handed from front to back
   typedef struct packed {
      logic       two;      // second result present
      logic [7:0] byte0;
      kind_type   kind0;
      logic       last0;
      kind_type   kind1;
      logic       is_text;
      logic       fin;
   } step_type;
endpackage

// ===== rtl/wsfd_front.sv =====
// wsfd_front: header parser and payload unmasking, one byte per cycle while go is high
// depends on wsfd_pkg
`timescale 1ns / 1ps
module wsfd_front import wsfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [7:0]  in_byte,
   input  logic        in_start,
   input  logic        in_end,
   input  logic [31:0] max_len,
   output logic        step_valid,
   output step_type    step
);
   typedef enum logic [2:0] {
      PH_IDLE, PH_LEN, PH_EXT, PH_MASK, PH_DATA
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  op_ff, op_in;
   logic [3:0]  ext_ff, ext_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [2:0]  mcnt_ff, mcnt_in;
   logic [31:0] left_ff, left_in;
   logic [1:0]  kidx_ff, kidx_in;
   logic        sv_in;
   step_type    st_in;
   logic        hit;
   logic [63:0] len_next;
   logic [7:0]  kb;

   always_comb begin
      phase_in = phase_ff; fin_in = fin_ff; op_in = op_ff; ext_in = ext_ff;
      len_in = len_ff; key_in = key_ff; mcnt_in = mcnt_ff; left_in = left_ff;
      kidx_in = kidx_ff;
      sv_in = 1'b0; hit = 1'b0;
      st_in = '0;
      len_next = '0;
      kb = '0;
      case (kidx_ff)
         2'd0: kb = key_ff[31:24];
         2'd1: kb = key_ff[23:16];
         2'd2: kb = key_ff[15:8];
         default: kb = key_ff[7:0];
      endcase
      if (in_start) begin
         fin_in = in_byte[7]; op_in = in_byte[3:0];
         ext_in = '0; len_in = '0; key_in = '0; mcnt_in = '0; left_in = '0;
         kidx_in = '0;
         if (in_byte[3:0] == OP_CLOSE) begin
            hit = 1'b1; st_in.kind0 = KIND_CLOSE; phase_in = PH_IDLE;
         end else if (in_byte[3:0] != OP_TEXT && in_byte[3:0] != OP_BINARY) begin
            hit = 1'b1; st_in.kind0 = KIND_BADOP; phase_in = PH_IDLE;
         end else phase_in = PH_LEN;
      end else begin
         unique case (phase_ff)
            PH_LEN: begin
               if (in_byte[6:0] <= 7'd125) begin
                  len_next = {57'd0, in_byte[6:0]};
                  len_in = len_next;
                  if (len_next > {32'd0, max_len}) begin
                     hit = 1'b1; st_in.kind0 = KIND_TOOLONG; phase_in = PH_IDLE;
                  end else begin
                     left_in = len_next[31:0]; mcnt_in = 3'd4; key_in = '0;
                     phase_in = PH_MASK;
                  end
               end else begin
                  len_in = '0;
                  ext_in = (in_byte[6:0] == 7'd126) ? 4'd2 : 4'd8;
                  phase_in = PH_EXT;
               end
            end
            PH_EXT: begin
               len_next = {len_ff[55:0], in_byte};
               len_in = len_next;
               if (ext_ff != 4'd0) ext_in = ext_ff - 4'd1;
               if (ext_ff <= 4'd1) begin
                  if (len_next > {32'd0, max_len}) begin
                     hit = 1'b1; st_in.kind0 = KIND_TOOLONG; phase_in = PH_IDLE;
                  end else begin
                     left_in = len_next[31:0]; mcnt_in = 3'd4; key_in = '0;
                     phase_in = PH_MASK;
                  end
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], in_byte};
               if (mcnt_ff != 3'd0) mcnt_in = mcnt_ff - 3'd1;
               if (mcnt_ff <= 3'd1) begin
                  kidx_in = '0;
                  if (left_ff == 32'd0) begin
                     hit = 1'b1;
                     st_in.kind0 = (op_ff == OP_TEXT) ? KIND_TERM : KIND_EMPTYBIN;
                     phase_in = PH_IDLE;
                  end else phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               hit = 1'b1;
               st_in.kind0 = KIND_PAYLOAD;
               st_in.byte0 = in_byte ^ kb;
               st_in.last0 = (left_ff <= 32'd1) && (op_ff != OP_TEXT);
               kidx_in = kidx_ff + 2'd1;
               if (left_ff != 32'd0) left_in = left_ff - 32'd1;
               if (left_ff <= 32'd1) begin
                  if (op_ff == OP_TEXT) begin
                     st_in.two = 1'b1; st_in.kind1 = KIND_TERM;
                  end
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      // early end of buffer
      if (in_end && phase_in != PH_IDLE) begin
         if (hit) begin
            st_in.two = 1'b1; st_in.kind1 = KIND_TRUNC;
         end else begin
            hit = 1'b1; st_in.kind0 = KIND_TRUNC;
         end
         phase_in = PH_IDLE;
      end
      if (st_in.kind0 != KIND_PAYLOAD) st_in.last0 = 1'b1;
      if (st_in.two) st_in.last0 = 1'b0;
      st_in.is_text = (op_in == OP_TEXT);
      st_in.fin = fin_in;
      sv_in = hit;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; fin_ff <= 1'b0; op_ff <= '0; ext_ff <= '0;
         len_ff <= '0; key_ff <= '0; mcnt_ff <= '0; left_ff <= '0;
         kidx_ff <= '0; step_valid <= 1'b0;
      end else begin
         step_valid <= go && sv_in;
         if (go) begin
            phase_ff <= phase_in; fin_ff <= fin_in; op_ff <= op_in;
            ext_ff <= ext_in; len_ff <= len_in; key_ff <= key_in;
            mcnt_ff <= mcnt_in; left_ff <= left_in; kidx_ff <= kidx_in;
         end
      end
   end

   // step payload
   always_ff @(posedge clock) begin
      if (go) step <= st_in;
   end
endmodule

// ===== rtl/wsfd_back.sv =====
// wsfd_back: step queue and result serializer
// depends on wsfd_pkg
`timescale 1ns / 1ps
module wsfd_back import wsfd_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  step_type   step,
   output logic       almost_full,
   input  logic       pop,
   output logic       empty,
   output logic [7:0] out_byte,
   output logic [2:0] kind,
   output logic       is_text,
   output logic       fin,
   output logic       last
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   step_type          mem [Depth];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [AW:0]       cnt_ff;
   logic              half_ff;
   step_type          head;
   logic              take;
   logic              done;

   assign head  = mem[rd_ff];
   assign empty = (cnt_ff == '0);
   // leave room for the step in flight in the front
   assign almost_full = (cnt_ff >= (AW+1)'(Depth - 2));
   assign take  = !empty && pop;
   assign done  = take && (!head.two || half_ff);

   always_comb begin
      if (half_ff) begin
         out_byte = '0; kind = head.kind1; last = 1'b1;
      end else begin
         out_byte = head.byte0; kind = head.kind0; last = head.last0;
      end
      is_text = head.is_text;
      fin = head.fin;
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (step_valid) mem[wr_ff] <= step;
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0; half_ff <= 1'b0;
      end else begin
         if (step_valid)
            wr_ff <= (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         if (done)
            rd_ff <= (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         if (take) half_ff <= head.two && !half_ff;
         cnt_ff <= cnt_ff + (AW+1)'(step_valid) - (AW+1)'(done);
      end
   end
endmodule

// ===== rtl/websocket_frame_decoder.sv =====
// websocket_frame_decoder: top level, front parser plus result queue
// depends on wsfd_pkg, wsfd_front, wsfd_back
//
// channel  ports                    transfer when
// req      req_push/full            push && !full
// rsp      rsp_pop/empty            pop && !empty
// csr      csr_we/csr_wdata         csr_we
//
// one byte per cycle in unless full; results leave one per cycle, a text
// end gives two. the parser output is registered; the queue of Depth steps
// absorbs bursts. full rises when the queue nears its limit, so pop stalls
// hold back req. reset is synchronous and clears the parser and queue.
`timescale 1ns / 1ps
module websocket_frame_decoder import wsfd_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_buffer_start,
   input  logic        req_buffer_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_result_kind,
   output logic        rsp_is_text,
   output logic        rsp_fin_flag,
   output logic        rsp_frame_last,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   logic [31:0] max_ff;
   logic        step_valid;
   step_type    step;
   logic        go;

   assign go = req_push && !req_full;

   // config register
   always_ff @(posedge clock) begin
      if (reset) max_ff <= MaxPayloadReset;
      else if (csr_we) max_ff <= csr_wdata;
   end

   wsfd_front u_front (
      .clock, .reset, .go,
      .in_byte(req_in_byte), .in_start(req_buffer_start), .in_end(req_buffer_end),
      .max_len(max_ff), .step_valid, .step
   );

   wsfd_back #(.Depth(Depth < 4 ? 4 : Depth)) u_back (
      .clock, .reset, .step_valid, .step, .almost_full(req_full),
      .pop(rsp_pop), .empty(rsp_empty), .out_byte(rsp_out_byte),
      .kind(rsp_result_kind), .is_text(rsp_is_text), .fin(rsp_fin_flag),
      .last(rsp_frame_last)
   );

`ifndef SYNTHESIS
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != KIND_PAYLOAD) |-> rsp_out_byte == 8'd0)
      else $error("non-payload result carries data");
   a_flag_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != KIND_PAYLOAD) |-> rsp_frame_last)
      else $error("status result not marked last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("result lost without pop");
`endif
endmodule

// ===== sim/tb_websocket_frame_decoder.sv =====
// tb_websocket_frame_decoder: self-checking bench for the websocket frame decoder
// depends on wsfd_pkg and websocket_frame_decoder; frame predictor and scoreboard inside
`timescale 1ns / 1ps
module tb_websocket_frame_decoder;
   import wsfd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
   } byte_item_t;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       text;
      logic       fin;
      logic       frame_end;
   } frame_result_t;

   typedef enum logic [2:0] {
      PH_IDLE, PH_LEN, PH_EXT, PH_MASK, PH_DATA
   } phase_t;

   localparam int StallMax = 12;
   localparam int Limit    = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_in_byte = '0;
   logic        req_buffer_start = 1'b0;
   logic        req_buffer_end = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_result_kind;
   logic        rsp_is_text;
   logic        rsp_fin_flag;
   logic        rsp_frame_last;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   websocket_frame_decoder dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_in_byte(req_in_byte), .req_buffer_start(req_buffer_start),
      .req_buffer_end(req_buffer_end),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte), .rsp_result_kind(rsp_result_kind),
      .rsp_is_text(rsp_is_text), .rsp_fin_flag(rsp_fin_flag),
      .rsp_frame_last(rsp_frame_last),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [31:0] max_len;
   phase_t      phase;
   logic        fin_bit;
   logic [3:0]  opcode;
   logic [3:0]  ext_left;
   logic [63:0] len_acc;
   logic [31:0] key;
   logic [2:0]  key_left;
   logic [31:0] data_left;
   logic [1:0]  key_pos;

   byte_item_t    pending_bytes[$];
   frame_result_t expected_results[$];
   int  errors = 0;
   int  bytes_sent = 0;
   int  results_seen = 0;
   int  idle_cycles = 0;

   function automatic void queue_result(logic [7:0] d, kind_type k, logic e);
      frame_result_t r;
      r.data = d;
      r.kind = k;
      r.text = (opcode == OP_TEXT);
      r.fin = fin_bit;
      r.frame_end = e;
      expected_results = {expected_results, r};
   endfunction

   function automatic void finish_length();
      if (len_acc > {32'd0, max_len}) begin
         queue_result(8'd0, KIND_TOOLONG, 1'b1);
         phase = PH_IDLE;
      end else begin
         data_left = len_acc[31:0];
         key_left = 3'd4;
         key = '0;
         phase = PH_MASK;
      end
   endfunction

   // expected results for one accepted byte
   function automatic void predict_frame_byte(byte_item_t it);
      logic [7:0] kb;
      logic       done;
      logic       text;
      if (it.first) begin
         fin_bit = it.data[7];
         opcode = it.data[3:0];
         ext_left = '0;
         len_acc = '0;
         key = '0;
         key_left = '0;
         data_left = '0;
         key_pos = '0;
         if (opcode == OP_CLOSE) begin
            queue_result(8'd0, KIND_CLOSE, 1'b1);
            phase = PH_IDLE;
         end else if (opcode != OP_TEXT && opcode != OP_BINARY) begin
            queue_result(8'd0, KIND_BADOP, 1'b1);
            phase = PH_IDLE;
         end else begin
            phase = PH_LEN;
         end
      end else begin
         case (phase)
            PH_LEN: begin
               if (it.data[6:0] <= 7'd125) begin
                  len_acc = {57'd0, it.data[6:0]};
                  finish_length();
               end else begin
                  len_acc = '0;
                  ext_left = (it.data[6:0] == 7'd126) ? 4'd2 : 4'd8;
                  phase = PH_EXT;
               end
            end
            PH_EXT: begin
               len_acc = {len_acc[55:0], it.data};
               if (ext_left != 0) ext_left = ext_left - 1'b1;
               if (ext_left == 0) finish_length();
            end
            PH_MASK: begin
               key = {key[23:0], it.data};
               if (key_left != 0) key_left = key_left - 1'b1;
               if (key_left == 0) begin
                  key_pos = '0;
                  if (data_left == 0) begin
                     if (opcode == OP_TEXT) queue_result(8'd0, KIND_TERM, 1'b1);
                     else queue_result(8'd0, KIND_EMPTYBIN, 1'b1);
                     phase = PH_IDLE;
                  end else begin
                     phase = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               kb = key[8 * (3 - key_pos) +: 8];
               done = (data_left <= 1);
               text = (opcode == OP_TEXT);
               queue_result(it.data ^ kb, KIND_PAYLOAD, done && !text);
               key_pos = key_pos + 1'b1;
               if (data_left != 0) data_left = data_left - 1'b1;
               if (done) begin
                  if (text) queue_result(8'd0, KIND_TERM, 1'b1);
                  phase = PH_IDLE;
               end
            end
            default: phase = PH_IDLE;
         endcase
      end
      if (it.last && phase != PH_IDLE) begin
         queue_result(8'd0, KIND_TRUNC, 1'b1);
         phase = PH_IDLE;
      end
   endfunction

   function automatic void add_byte(logic [7:0] d, logic s, logic e);
      byte_item_t it;
      it.data = d;
      it.first = s;
      it.last = e;
      pending_bytes = {pending_bytes, it};
   endfunction

   // one frame buffer: header, length field, key, payload; optional early end
   function automatic void add_frame(logic [3:0] op, int len, int ext_kind, int cut);
      byte_item_t buf_q[$];
      byte_item_t it;
      logic [63:0] l64;
      it.first = 1'b0;
      it.last = 1'b0;
      it.data = {$urandom_range(0, 1) == 1, 3'($urandom), op};
      buf_q = {buf_q, it};
      l64 = 64'(len);
      if (ext_kind == 0) begin
         it.data = {1'($urandom), 7'(len)};
         buf_q = {buf_q, it};
      end else if (ext_kind == 1) begin
         it.data = {1'($urandom), 7'd126};
         buf_q = {buf_q, it};
         for (int i = 1; i >= 0; i--) begin
            it.data = l64[8 * i +: 8];
            buf_q = {buf_q, it};
         end
      end else begin
         it.data = {1'($urandom), 7'd127};
         buf_q = {buf_q, it};
         for (int i = 7; i >= 0; i--) begin
            it.data = l64[8 * i +: 8];
            buf_q = {buf_q, it};
         end
      end
      for (int i = 0; i < 4 + (len > 40 ? 40 : len); i++) begin
         it.data = 8'($urandom);
         buf_q = {buf_q, it};
      end
      if (cut > 0 && cut < buf_q.size()) buf_q = buf_q[0:cut - 1];
      buf_q[0].first = 1'b1;
      buf_q[buf_q.size() - 1].last = ($urandom_range(0, 3) != 0);
      pending_bytes = {pending_bytes, buf_q};
   endfunction

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || expected_results.size() != 0 || req_push)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_max_len(logic [31:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      max_len = v;
   endtask

   // sampled handshake state at the rising edge
   logic req_taken = 1'b0;
   int   pop_gap = 0;
   int   send_gap = 0;

   // driver: next byte at the falling edge, random gaps between transfers
   always @(negedge clock) begin
      if (!reset && (!req_push || req_taken)) begin
         if (req_push) begin
            send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, StallMax);
         end else if (send_gap > 0) begin
            send_gap--;
         end
         if (send_gap == 0 && pending_bytes.size() != 0) begin
            req_push <= 1'b1;
            req_in_byte <= pending_bytes[0].data;
            req_buffer_start <= pending_bytes[0].first;
            req_buffer_end <= pending_bytes[0].last;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // input transfers feed the predictor
   always @(posedge clock) begin
      req_taken = !reset && req_push && !req_full;
      if (req_taken) begin
         predict_frame_byte(pending_bytes.pop_front());
         bytes_sent++;
      end
   end

   // monitor: compare each popped result with the oldest expectation
   always @(posedge clock) begin
      frame_result_t exp_r;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         idle_cycles <= 0;
         if (expected_results.size() == 0) begin
            $error("unexpected result kind=%0d byte=%0h", rsp_result_kind, rsp_out_byte);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_out_byte !== exp_r.data) begin
               $error("out_byte exp %0h got %0h", exp_r.data, rsp_out_byte); errors++;
            end
            if (rsp_result_kind !== exp_r.kind) begin
               $error("result_kind exp %0d got %0d", exp_r.kind, rsp_result_kind); errors++;
            end
            if (rsp_is_text !== exp_r.text) begin
               $error("is_text exp %0b got %0b", exp_r.text, rsp_is_text); errors++;
            end
            if (rsp_fin_flag !== exp_r.fin) begin
               $error("fin_flag exp %0b got %0b", exp_r.fin, rsp_fin_flag); errors++;
            end
            if (rsp_frame_last !== exp_r.frame_end) begin
               $error("frame_last exp %0b got %0b", exp_r.frame_end, rsp_frame_last);
               errors++;
            end
         end
      end else if (!reset && req_push && !req_full) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else if (rsp_pop && !rsp_empty) begin
         pop_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, StallMax);
         rsp_pop <= (pop_gap == 0);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // watchdog on cycles without a transfer
   always @(posedge clock) begin
      if (idle_cycles >= Limit) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int op_pick;
      int len;
      max_len = MaxPayloadReset;
      phase = PH_IDLE;
      fin_bit = 0; opcode = 0; ext_left = 0; len_acc = 0;
      key = 0; key_left = 0; data_left = 0; key_pos = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every opcode class, length forms, empty frames, early end
      add_byte(8'h88, 1'b1, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b1);
      add_byte(8'h89, 1'b1, 1'b1);
      add_byte(8'h00, 1'b0, 1'b0);
      add_frame(OP_TEXT, 0, 0, 0);
      add_frame(OP_BINARY, 0, 0, 0);
      add_frame(OP_TEXT, 3, 0, 0);
      add_frame(OP_BINARY, 5, 0, 4);
      add_byte(8'h82, 1'b1, 1'b0);
      add_byte(8'hFE, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b1);
      add_byte(8'h81, 1'b1, 1'b0);
      add_byte(8'h7F, 1'b0, 1'b0);
      for (int i = 0; i < 8; i++) add_byte(8'hFF, 1'b0, i == 7);
      wait_drained();

      // zero and all-ones limits with short and extended length forms
      write_max_len(32'd0);
      add_frame(OP_BINARY, 1, 0, 0);
      add_frame(OP_TEXT, 0, 2, 0);
      add_frame(OP_BINARY, 2, 1, 0);
      wait_drained();
      write_max_len(32'hFFFF_FFFF);
      add_frame(OP_BINARY, 6, 2, 0);
      add_frame(OP_TEXT, 2, 1, 0);
      wait_drained();
      write_max_len(32'd20);

      // random frames, mostly well formed
      while (bytes_sent + pending_bytes.size() < 700) begin
         op_pick = $urandom_range(0, 9);
         len = $urandom_range(0, 30);
         if (op_pick < 8)
            add_frame(op_pick < 4 ? OP_TEXT : OP_BINARY, len,
                      $urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : 0,
                      $urandom_range(0, 5) == 0 ? $urandom_range(1, 12) : 0);
         else if (op_pick == 8)
            add_byte({1'($urandom), 3'($urandom), 4'($urandom)}, 1'b1, 1'($urandom));
         else
            add_byte(8'($urandom), 1'b0, 1'($urandom));
         if (pending_bytes.size() > 300 && max_len == 32'd20) begin
            wait_drained();
            write_max_len(32'd125);
         end
      end
      wait_drained();

      $display("checked %0d bytes and %0d results over several length limits",
                bytes_sent, results_seen);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== websocket_frame_decoder.f =====
rtl/wsfd_pkg.sv
rtl/wsfd_front.sv
rtl/wsfd_back.sv
rtl/websocket_frame_decoder.sv
sim/tb_websocket_frame_decoder.sv
